// ----- rtl/pwa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwa_pkg: shared constants and types of the pulse width averager
// Widths of the ring, running sum and shared divider, plus the divider
// request and response bundles.
// ----------------------------------------------------------------------------
package pwa_pkg;

   localparam int DEPTH      = 20;
   localparam int COUNT_BITS = 24;
   localparam int FIELD_W    = 24;
   localparam int EDGE_W     = 32;
   localparam int CPU_W      = 8;
   localparam logic [CPU_W-1:0] CPU_RESET = 8'd20;

   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SUM_W  = COUNT_BITS + ((DEPTH > 1) ? $clog2(DEPTH) : 0);
   localparam int NUM_W  = ((SUM_W + 2) / 2) * 2;
   localparam int DEN_W  = CPU_W + 1;
   localparam int STEPS  = NUM_W / 2;
   localparam int CNT_W  = (STEPS > 1) ? $clog2(STEPS) : 1;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numer;
      logic [DEN_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quot;
   } div_rsp_type;

endpackage

// ----- rtl/pwa_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwa_div: shared restoring divider
// Two quotient bits per cycle; the numerator register shifts out dividend
// bits and takes in quotient bits. done pulses when quot is valid.
// ----------------------------------------------------------------------------
module pwa_div (
   input  logic                 clock,
   input  logic                 reset,
   input  pwa_pkg::div_req_type div_req,
   output pwa_pkg::div_rsp_type div_rsp
);

   logic [pwa_pkg::NUM_W-1:0] work_ff, work_in;
   logic [pwa_pkg::DEN_W-1:0] rem_ff, rem_in;
   logic [pwa_pkg::DEN_W-1:0] denom_ff, denom_in;
   logic [pwa_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;

   logic [pwa_pkg::DEN_W:0]   trial1, trial2, dext;
   logic [pwa_pkg::DEN_W-1:0] r1, r2;
   logic                      q1, q2;

   always_comb begin
      dext   = {1'b0, denom_ff};
      trial1 = {rem_ff, work_ff[pwa_pkg::NUM_W-1]};
      q1     = (trial1 >= dext);
      r1     = q1 ? pwa_pkg::DEN_W'(trial1 - dext) : trial1[pwa_pkg::DEN_W-1:0];
      trial2 = {r1, work_ff[pwa_pkg::NUM_W-2]};
      q2     = (trial2 >= dext);
      r2     = q2 ? pwa_pkg::DEN_W'(trial2 - dext) : trial2[pwa_pkg::DEN_W-1:0];
   end

   always_comb begin
      work_in  = work_ff;
      rem_in   = rem_ff;
      denom_in = denom_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (div_req.start) begin
         work_in  = div_req.numer;
         rem_in   = '0;
         denom_in = div_req.denom;
         cnt_in   = pwa_pkg::CNT_W'(pwa_pkg::STEPS - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         work_in = {work_ff[pwa_pkg::NUM_W-3:0], q1, q2};
         rem_in  = r2;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      denom_ff <= denom_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = work_ff;

endmodule

// ----- rtl/pwa_ring.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwa_ring: width history ring with running sum
// Overwrites the oldest width on each store and keeps the sum of all
// entries; entries never written read as zero through their valid bits.
// The entry due for overwrite is fetched into a register ahead of its store.
// ----------------------------------------------------------------------------
module pwa_ring (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           store,
   input  logic [pwa_pkg::COUNT_BITS-1:0] width,
   output logic [pwa_pkg::SUM_W-1:0]      sum
);

   logic [pwa_pkg::COUNT_BITS-1:0] ring_mem [pwa_pkg::DEPTH];
   logic [pwa_pkg::DEPTH-1:0]      valid_ff, valid_in;
   logic [pwa_pkg::SLOT_W-1:0]     slot_ff, slot_in;
   logic [pwa_pkg::SUM_W-1:0]      sum_ff, sum_in;
   logic [pwa_pkg::COUNT_BITS-1:0] old_ff;

   always_comb begin
      valid_in  = valid_ff;
      slot_in   = slot_ff;
      sum_in    = sum_ff;
      if (store) begin
         valid_in[slot_ff] = 1'b1;
         sum_in = sum_ff - pwa_pkg::SUM_W'(old_ff) + pwa_pkg::SUM_W'(width);
         if (slot_ff == pwa_pkg::SLOT_W'(pwa_pkg::DEPTH - 1)) begin
            slot_in = '0;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         ring_mem[slot_ff] <= width;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         slot_ff  <= '0;
         sum_ff   <= '0;
         old_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         slot_ff  <= slot_in;
         sum_ff   <= sum_in;
         if (store && (slot_in == slot_ff)) begin
            old_ff <= width;
         end else if (valid_in[slot_in]) begin
            old_ff <= ring_mem[slot_in];
         end else begin
            old_ff <= '0;
         end
      end
   end

   assign sum = sum_ff;

endmodule

// ----- rtl/pulse_width_averager.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_averager: pulse width measurement with moving average
// Measures high-pulse widths from down-counter samples taken at pin edges,
// averages the last DEPTH widths and converts the mean to microseconds.
//
// channel  dir  handshake               payload
// req      in   req_tvalid/req_tready   tuser pin_level, tdata counter_sample
// rsp      out  rsp_tvalid/rsp_tready   tuser width_stored, tdata results
// csr      in   csr_valid/csr_ready     csr_data clocks_per_us
//
// an item runs twice through the shared two-bit-per-cycle divider, once for the
// mean and once for microseconds, before the next accept; rsp_tvalid rises when
// the results are loaded into the output register
// req_tready is high only while idle; a finished item waits in the output
// register and the next item is taken meanwhile
// a stalled rsp holds the sequencer before the output load only
// synchronous reset clears the ring valid bits, sum, counters and state
// ----------------------------------------------------------------------------
module pulse_width_averager (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // counter_sample
   input  logic         req_tuser,   // pin_level
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // latest_width, mean_clocks, mean_us, edge_total
   output logic         rsp_tuser,   // width_stored
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_data     // clocks_per_us
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN,
      ST_MEAN_WAIT,
      ST_US,
      ST_US_WAIT,
      ST_OUT
   } state_type;

   state_type                      state_ff, state_in;
   logic [pwa_pkg::COUNT_BITS-1:0] prev_ff, prev_in;
   logic [pwa_pkg::COUNT_BITS-1:0] last_ff, last_in;
   logic [pwa_pkg::EDGE_W-1:0]     edge_ff, edge_in;
   logic                           stored_ff, stored_in;
   logic [pwa_pkg::FIELD_W-1:0]    mean_ff, mean_in;
   logic [pwa_pkg::FIELD_W-1:0]    us_ff, us_in;
   logic [pwa_pkg::CPU_W-1:0]      cpu_ff, cpu_in;
   logic                           rsp_tvalid_ff, rsp_tvalid_in;
   logic [103:0]                   rsp_tdata_ff, rsp_tdata_in;
   logic                           rsp_tuser_ff, rsp_tuser_in;

   logic                           accept;
   logic                           store;
   logic [pwa_pkg::COUNT_BITS-1:0] width;
   logic [pwa_pkg::SUM_W-1:0]      sum;
   logic [pwa_pkg::CPU_W-1:0]      div_cpu;
   pwa_pkg::div_req_type           div_req;
   pwa_pkg::div_rsp_type           div_rsp;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign width      = prev_ff - req_tdata;
   assign store      = accept & ~req_tuser;
   assign div_cpu    = (cpu_ff == '0) ? pwa_pkg::CPU_W'(1) : cpu_ff;
   assign csr_ready  = 1'b1;

   pwa_ring u_ring (
      .clock (clock),
      .reset (reset),
      .store (store),
      .width (width),
      .sum   (sum)
   );

   always_comb begin
      div_req.start = 1'b0;
      div_req.numer = pwa_pkg::NUM_W'({sum, 1'b0}) + pwa_pkg::NUM_W'(pwa_pkg::DEPTH);
      div_req.denom = pwa_pkg::DEN_W'(2 * pwa_pkg::DEPTH);
      case (state_ff)
         ST_MEAN: begin
            div_req.start = 1'b1;
         end
         ST_US: begin
            div_req.start = 1'b1;
            div_req.numer = pwa_pkg::NUM_W'({mean_ff, 1'b0}) + pwa_pkg::NUM_W'(div_cpu);
            div_req.denom = {div_cpu, 1'b0};
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   pwa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in      = state_ff;
      prev_in       = prev_ff;
      last_in       = last_ff;
      edge_in       = edge_ff;
      stored_in     = stored_ff;
      mean_in       = mean_ff;
      us_in         = us_ff;
      cpu_in        = cpu_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;

      if (csr_valid) begin
         cpu_in = csr_data;
      end
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               prev_in   = req_tdata;
               edge_in   = edge_ff + 1'b1;
               stored_in = ~req_tuser;
               if (!req_tuser) begin
                  last_in = width;
               end
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            state_in = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (div_rsp.done) begin
               mean_in  = div_rsp.quot[pwa_pkg::FIELD_W-1:0];
               state_in = ST_US;
            end
         end
         ST_US: begin
            state_in = ST_US_WAIT;
         end
         ST_US_WAIT: begin
            if (div_rsp.done) begin
               us_in    = div_rsp.quot[pwa_pkg::FIELD_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {edge_ff, us_ff, mean_ff, pwa_pkg::FIELD_W'(last_ff)};
               rsp_tuser_in  = stored_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mean_ff      <= mean_in;
      us_ff        <= us_in;
      stored_ff    <= stored_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         prev_ff       <= '0;
         last_ff       <= '0;
         edge_ff       <= '0;
         cpu_ff        <= pwa_pkg::CPU_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_ff       <= prev_in;
         last_ff       <= last_in;
         edge_ff       <= edge_in;
         cpu_ff        <= cpu_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("accepted a new item while busy");

   a_edge_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> edge_ff == $past(edge_ff) + 32'd1)
      else $error("edge counter did not advance on an item");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_MEAN_WAIT || state_ff == ST_US_WAIT))
      else $error("divider finished outside a wait state");

endmodule
